FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted (active low)
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Expression must never be true at a sampled edge
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  `ASSERT_AT(lbl, clk, rst_n, !(expr))

`endif

FILE: hdl/cclp_pkg.sv
// ----------------------------------------------------------------------------
// cclp_pkg
// Types, constants and colour tables for the colour command line parser.
// ----------------------------------------------------------------------------
package cclp_pkg;

  // Width of the line byte counter
  localparam int LINE_COUNT_BITS = 12;
  localparam int MAX_CHARS_W     = 12;
  localparam int EV_LIMIT_W      = 8;
  localparam int LINE_CMP_W      = (LINE_COUNT_BITS > MAX_CHARS_W) ?
                                   LINE_COUNT_BITS : MAX_CHARS_W;

  localparam int NUM_COLOURS = 8;
  localparam int NAME_SLOTS  = 8;

  // APB register map
  localparam int  APB_ADDR_W = 3;
  localparam int  APB_DATA_W = 32;
  localparam logic REG_EV_LIMIT   = 1'b0;
  localparam logic REG_MAX_CHARS  = 1'b1;
  localparam logic [EV_LIMIT_W-1:0]  EV_LIMIT_RST   = 8'd10;
  localparam logic [MAX_CHARS_W-1:0] MAX_CHARS_RST  = 12'd255;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // Magnitude clamps at 2^31
  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

  // Token parsing phases
  typedef enum logic [2:0] {
    PH_LEAD,
    PH_WORD,
    PH_GAP,
    PH_SIGN,
    PH_DIGITS,
    PH_AFTER,
    PH_DEAD
  } phase_e;

  typedef struct packed {
    logic [EV_LIMIT_W-1:0]  ev_limit;
    logic [MAX_CHARS_W-1:0] max_chars;
  } cfg_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [2:0]         colour_index;
    rgb_t               rgb;
    logic signed [31:0] duration_ms;
  } event_t;

  localparam rgb_t COLOUR_RGB [NUM_COLOURS] = '{
    '{8'd255, 8'd0,   8'd0},
    '{8'd0,   8'd255, 8'd0},
    '{8'd0,   8'd0,   8'd255},
    '{8'd255, 8'd255, 8'd0},
    '{8'd255, 8'd128, 8'd0},
    '{8'd128, 8'd0,   8'd255},
    '{8'd255, 8'd255, 8'd255},
    '{8'd0,   8'd0,   8'd0}
  };

  localparam logic [3:0] NAME_LEN [NUM_COLOURS] = '{
    4'd3, 4'd5, 4'd4, 4'd6, 4'd6, 4'd6, 4'd5, 4'd5
  };

  // Upper-case names, padded with NUL
  localparam logic [7:0] NAME_CHARS [NUM_COLOURS][NAME_SLOTS] = '{
    '{"R", "E", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"G", "R", "E", "E", "N", 8'h00, 8'h00, 8'h00},
    '{"B", "L", "U", "E", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"Y", "E", "L", "L", "O", "W", 8'h00, 8'h00},
    '{"O", "R", "A", "N", "G", "E", 8'h00, 8'h00},
    '{"V", "I", "O", "L", "E", "T", 8'h00, 8'h00},
    '{"W", "H", "I", "T", "E", 8'h00, 8'h00, 8'h00},
    '{"B", "L", "A", "C", "K", 8'h00, 8'h00, 8'h00}
  };

endpackage

FILE: hdl/cclp_cfg.sv
// ----------------------------------------------------------------------------
// cclp_cfg
// APB register file: events-per-line limit and kept-bytes-per-line limit.
// ----------------------------------------------------------------------------
module cclp_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cclp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [cclp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [cclp_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output cclp_pkg::cfg_t                 cfg_o
);
  import cclp_pkg::*;

  logic [EV_LIMIT_W-1:0]   ev_limit_q;
  logic [MAX_CHARS_W-1:0]  max_chars_q;
  logic                    wr_en;
  logic                    reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[APB_ADDR_W-1];
  assign pready  = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_limit_q  <= EV_LIMIT_RST;
      max_chars_q <= MAX_CHARS_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_EV_LIMIT:  ev_limit_q  <= pwdata[EV_LIMIT_W-1:0];
        REG_MAX_CHARS: max_chars_q <= pwdata[MAX_CHARS_W-1:0];
        default:       ev_limit_q  <= ev_limit_q;
      endcase
    end
  end

  // Read-back
  always_comb begin
    unique case (reg_sel)
      REG_EV_LIMIT:  prdata = APB_DATA_W'(ev_limit_q);
      REG_MAX_CHARS: prdata = APB_DATA_W'(max_chars_q);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.ev_limit  = ev_limit_q;
  assign cfg_o.max_chars = max_chars_q;

endmodule

FILE: hdl/cclp_parser.sv
// ----------------------------------------------------------------------------
// cclp_parser
// Per-byte line and token state; flags an event when a valid token closes.
// ----------------------------------------------------------------------------
module cclp_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  cclp_pkg::cfg_t   cfg_i,
  output logic             fire_o,
  output cclp_pkg::event_t event_o
);
  import cclp_pkg::*;

  logic [LINE_COUNT_BITS-1:0] len_q, len_d;
  logic                       cut_q, cut_d;
  phase_e                     phase_q, phase_d, phase_feed;
  logic [NUM_COLOURS-1:0]     cand_q, cand_d, cand_char, len_match;
  logic [3:0]                 pos_q, pos_d, pos_inc;
  logic [31:0]                mag_q, mag_d, mag_dig;
  logic                       neg_q, neg_d;
  logic [EV_LIMIT_W-1:0]      events_q, events_d;

  logic [7:0]  up_char;
  logic        is_ws, is_dig, is_sign;
  logic        line_full, close_ok;
  logic [35:0] mag_prod;
  logic [2:0]  colour_idx;

  // Byte classes
  assign is_ws   = (byte_i == CH_SPACE) || (byte_i == CH_TAB) ||
                   (byte_i == CH_VT)    || (byte_i == CH_FF);
  assign is_dig  = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign is_sign = (byte_i == CH_PLUS) || (byte_i == CH_MINUS);
  assign up_char = ((byte_i >= CH_LOW_A) && (byte_i <= CH_LOW_Z)) ?
                   byte_i - CASE_GAP : byte_i;

  // Name matching against all colours at the current position
  always_comb begin
    for (int i = 0; i < NUM_COLOURS; i++) begin
      len_match[i] = (NAME_LEN[i] == pos_q);
      cand_char[i] = cand_q[i] && (pos_q < NAME_LEN[i]) &&
                     (NAME_CHARS[i][pos_q[2:0]] == up_char);
    end
  end
  assign pos_inc = (pos_q == 4'hF) ? pos_q : pos_q + 4'd1;

  // Decimal accumulate, clamped at 2^31
  assign mag_prod = ({4'd0, mag_q} << 3) + ({4'd0, mag_q} << 1) +
                    36'(byte_i - CH_ZERO);
  assign mag_dig  = (mag_prod > 36'(MAG_LIMIT)) ? MAG_LIMIT : mag_prod[31:0];

  // Line byte budget
  assign line_full = cut_q ||
                     (LINE_CMP_W'(len_q) >= LINE_CMP_W'(cfg_i.max_chars)) ||
                     (len_q == {LINE_COUNT_BITS{1'b1}});

  // Token close check and event payload
  assign close_ok = ((phase_q == PH_DIGITS) || (phase_q == PH_AFTER)) &&
                    (|cand_q) && (events_q < cfg_i.ev_limit);

  always_comb begin
    colour_idx = 3'd7;
    for (int i = NUM_COLOURS - 2; i >= 0; i--) begin
      if (cand_q[i]) colour_idx = 3'(i);
    end
  end

  assign event_o.colour_index = colour_idx;
  assign event_o.rgb          = COLOUR_RGB[colour_idx];
  assign event_o.duration_ms  = neg_q ? (32'd0 - mag_q) :
                                (mag_q[31] ? POS_MAX : mag_q);

  // Token phase next state for an ordinary byte
  always_comb begin
    unique case (phase_q)
      PH_LEAD:   phase_feed = is_ws ? PH_LEAD : PH_WORD;
      PH_WORD: begin
        if (!is_ws)                      phase_feed = PH_WORD;
        else if (|(cand_q & len_match))  phase_feed = PH_GAP;
        else                             phase_feed = PH_DEAD;
      end
      PH_GAP: begin
        if (is_ws)        phase_feed = PH_GAP;
        else if (is_sign) phase_feed = PH_SIGN;
        else if (is_dig)  phase_feed = PH_DIGITS;
        else              phase_feed = PH_DEAD;
      end
      PH_SIGN:   phase_feed = is_dig ? PH_DIGITS : PH_DEAD;
      PH_DIGITS: phase_feed = is_dig ? PH_DIGITS : PH_AFTER;
      PH_AFTER:  phase_feed = PH_AFTER;
      PH_DEAD:   phase_feed = PH_DEAD;
      default:   phase_feed = PH_DEAD;
    endcase
  end

  // Per-byte state update and event strobe
  always_comb begin
    len_d    = len_q;
    cut_d    = cut_q;
    phase_d  = phase_q;
    cand_d   = cand_q;
    pos_d    = pos_q;
    mag_d    = mag_q;
    neg_d    = neg_q;
    events_d = events_q;
    fire_o   = 1'b0;
    if (step_i) begin
      priority if ((byte_i == CH_LF) || (byte_i == CH_CR)) begin
        fire_o   = close_ok;
        len_d    = '0;
        cut_d    = 1'b0;
        events_d = '0;
        phase_d  = PH_LEAD;
        cand_d   = '1;
        pos_d    = '0;
        mag_d    = '0;
        neg_d    = 1'b0;
      end else if (line_full) begin
        fire_o = 1'b0;
      end else if (byte_i == CH_NUL) begin
        len_d = len_q + 1'b1;
        cut_d = 1'b1;
      end else if (byte_i == CH_COMMA) begin
        len_d    = len_q + 1'b1;
        fire_o   = close_ok;
        events_d = events_q + EV_LIMIT_W'(close_ok);
        phase_d  = PH_LEAD;
        cand_d   = '1;
        pos_d    = '0;
        mag_d    = '0;
        neg_d    = 1'b0;
      end else begin
        len_d   = len_q + 1'b1;
        phase_d = phase_feed;
        unique case (phase_q)
          PH_LEAD: begin
            if (!is_ws) begin
              cand_d = cand_char;
              pos_d  = pos_inc;
            end
          end
          PH_WORD: begin
            if (is_ws) begin
              cand_d = cand_q & len_match;
            end else begin
              cand_d = cand_char;
              pos_d  = pos_inc;
            end
          end
          PH_GAP: begin
            if (!is_ws && is_sign) neg_d = (byte_i == CH_MINUS);
            else if (!is_ws && is_dig) mag_d = mag_dig;
          end
          PH_SIGN, PH_DIGITS: begin
            if (is_dig) mag_d = mag_dig;
          end
          default: mag_d = mag_q;
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      cut_q    <= 1'b0;
      phase_q  <= PH_LEAD;
      cand_q   <= '1;
      pos_q    <= '0;
      mag_q    <= '0;
      neg_q    <= 1'b0;
      events_q <= '0;
    end else begin
      len_q    <= len_d;
      cut_q    <= cut_d;
      phase_q  <= phase_d;
      cand_q   <= cand_d;
      pos_q    <= pos_d;
      mag_q    <= mag_d;
      neg_q    <= neg_d;
      events_q <= events_d;
    end
  end

endmodule

FILE: hdl/color_command_line_parser.sv
// ----------------------------------------------------------------------------
// color_command_line_parser
// Parses "colour number" tokens from a text byte stream into RGB events.
// ----------------------------------------------------------------------------
// Use:
//   Input channel (in_valid_i/in_ready_o, rx_byte_i) carries one text byte
//   per item. Output channel (out_valid_o/out_ready_i) carries one event:
//   colour index, RGB and signed duration. A byte gives zero or one event;
//   an event leaves at the comma or CR/LF that closes its token. Limits are
//   set over the APB port (0x0 events per line, 0x4 kept bytes per line)
//   by the user only while the block is idle; the block does not enforce it.
// Timing:
//   One byte per cycle sustained while the output is not held back. An
//   accepted byte waits in the input register, is parsed from there, and
//   its event is registered in the output register. The rate is set by the
//   combinational parser update between the input and output registers.
// Reset:
//   Clears both registers' valid flags and all line/token state; limits
//   return to 10 events and 255 bytes.
// Stall:
//   While an event waits untaken, the held byte waits in the input register
//   and in_ready_o drops once that register is full.
// ----------------------------------------------------------------------------
module color_command_line_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cclp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [cclp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [cclp_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      rx_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [2:0]                      color_index_o,
  output logic [7:0]                      red_o,
  output logic [7:0]                      green_o,
  output logic [7:0]                      blue_o,
  output logic signed [31:0]              duration_ms_o
);
  import cclp_pkg::*;

  cfg_t       cfg;
  event_t     ev;
  logic       fire;
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       out_valid_q, out_valid_d;
  event_t     out_ev_q;
  logic       go, step, in_acc;

  cclp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake: parse when the output slot is free or draining
  assign go         = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && go;
  assign in_ready_o = !in_valid_q || go;
  assign in_acc     = in_valid_i && in_ready_o;

  cclp_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (in_byte_q),
    .cfg_i   (cfg),
    .fire_o  (fire),
    .event_o (ev)
  );

  // Valid flags of the input and output registers
  always_comb begin
    in_valid_d  = in_acc ? 1'b1 : (step ? 1'b0 : in_valid_q);
    out_valid_d = (step && fire) ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= rx_byte_i;
    end
    if (step && fire) begin
      out_ev_q <= ev;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign color_index_o = out_ev_q.colour_index;
  assign red_o         = out_ev_q.rgb.r;
  assign green_o       = out_ev_q.rgb.g;
  assign blue_o        = out_ev_q.rgb.b;
  assign duration_ms_o = out_ev_q.duration_ms;

endmodule

FILE: hdl/cclp_checker.sv
// ----------------------------------------------------------------------------
// cclp_checker
// Port-level checks for the colour command line parser, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cclp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               pready,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [2:0]         color_index_o,
  input logic [7:0]         red_o,
  input logic [7:0]         green_o,
  input logic [7:0]         blue_o,
  input logic signed [31:0] duration_ms_o
);
  import cclp_pkg::*;

  logic        out_stall;
  logic        rgb_ok;
  logic [34:0] out_payload;

  // Output held back by the receiver
  assign out_stall   = out_valid_o && !out_ready_i;
  assign out_payload = {color_index_o, duration_ms_o};
  assign rgb_ok      = (red_o == COLOUR_RGB[color_index_o].r) &&
                       (green_o == COLOUR_RGB[color_index_o].g) &&
                       (blue_o == COLOUR_RGB[color_index_o].b);

  // Register port never inserts wait states
  `ASSERT_AT(a_pready_high, clk_i, rst_ni, pready)

  // Intensities always belong to the reported colour
  `ASSERT_AT(a_rgb_matches, clk_i, rst_ni, out_valid_o |-> rgb_ok)

  // Input side only stalls because of output back-pressure
  `ASSERT_NEVER(a_stall_cause, clk_i, rst_ni, !in_ready_o && !out_stall)

  // An untaken event holds
  `ASSERT_AT(a_out_hold, clk_i, rst_ni, out_stall |=> (out_valid_o && $stable(out_payload)))

endmodule

bind color_command_line_parser cclp_checker u_cclp_checker (.*);
